// ===== src/pfma_pkg.sv =====
package pfma_pkg;

	// Field widths of the stream items
	localparam int CMD_W      = 3;
	localparam int ADDR_W     = 14;
	localparam int BYTE_W     = 8;
	localparam int FRAME_W    = 6;
	localparam int STATUS_W   = 3;
	localparam int MSIZE_W    = 15;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = MSIZE_W;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM   = 1'd1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FORMAT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FREE   = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOFRAME = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FMT,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic exec;
		logic fmt_init;
		logic fmt_step;
		logic fmt_finish;
		logic load_out;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_format;
		logic fmt_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== src/pfma_ram.sv =====
module pfma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/pfma_ctrl.sv =====
module pfma_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pfma_pkg::dp_status_t  stat,
	output pfma_pkg::ctl_cmd_t    ctl
);

	pfma_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfma_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pfma_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_d     = pfma_pkg::S_EXEC;
				end
			end
			pfma_pkg::S_EXEC: begin
				if (stat.is_format) begin
					ctl.fmt_init = 1'b1;
					state_d      = pfma_pkg::S_FMT;
				end else begin
					ctl.exec = 1'b1;
					state_d  = pfma_pkg::S_DONE;
				end
			end
			pfma_pkg::S_FMT: begin
				if (stat.fmt_done) begin
					ctl.fmt_finish = 1'b1;
					state_d        = pfma_pkg::S_DONE;
				end else begin
					ctl.fmt_step = 1'b1;
				end
			end
			pfma_pkg::S_DONE: begin
				if (stat.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = pfma_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pfma_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/pfma_dp.sv =====
module pfma_dp #(
	parameter int MEM_BYTES  = 16384,
	parameter int PAGE_BYTES = 256,
	parameter int MAX_FRAMES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pfma_pkg::ctl_cmd_t                  ctl,
	output pfma_pkg::dp_status_t                stat,
	input  logic [pfma_pkg::IN_DATA_W-1:0]      in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pfma_pkg::OUT_DATA_W-1:0]     out_data,
	input  logic                                cfg_we,
	input  logic [pfma_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfma_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int LIM_RAW = $clog2(MEM_BYTES + 1);
	localparam int LW = (LIM_RAW > pfma_pkg::MSIZE_W) ? LIM_RAW : pfma_pkg::MSIZE_W;
	localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
	localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam logic [LW-1:0] LIM_MAX  = LW'(MEM_BYTES);
	localparam logic [LW-1:0] PAGE_LW  = LW'(PAGE_BYTES);
	localparam logic [CW-1:0] FRM_MAX  = CW'(MAX_FRAMES);

	// Accepted item
	logic [pfma_pkg::CMD_W-1:0]   cmd_q;
	logic [pfma_pkg::ADDR_W-1:0]  addr_q;
	logic [pfma_pkg::BYTE_W-1:0]  wbyte_q;
	logic [pfma_pkg::FRAME_W-1:0] fin_q;

	// Configuration and architectural state
	logic [pfma_pkg::MSIZE_W-1:0] mem_size_q;
	logic                         random_q;
	logic [pfma_pkg::ADDR_W-1:0]  cursor_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                wm_q;     // entries below this still hold formatted values
	logic [CW-1:0]                fbase_q;  // frame count of the last format

	// Format walk
	logic [LW-1:0] fmt_rem_q;
	logic [CW-1:0] fmt_cnt_q;

	// Result being built
	logic [pfma_pkg::STATUS_W-1:0] res_status_q;
	logic                          rd_ok_q;
	logic                          al_ok_q;
	logic                          pris_q;
	logic [pfma_pkg::FRAME_W-1:0]  pval_q;

	logic                          out_valid_q;
	logic [pfma_pkg::OUT_DATA_W-1:0] out_data_q;

	logic [LW-1:0]                 lim;
	logic                          in_range;
	logic [CW-1:0]                 pop_idx;
	logic [pfma_pkg::BYTE_W-1:0]   byte_rd;
	logic [pfma_pkg::FRAME_W-1:0]  stk_rd;
	logic                          byte_we, byte_re, stk_we, stk_re;
	logic [pfma_pkg::STATUS_W-1:0] ex_status;
	logic                          ex_rd_ok;
	logic                          ex_al_ok;
	logic [pfma_pkg::BYTE_W-1:0]   rb_out;
	logic [pfma_pkg::FRAME_W-1:0]  fr_out;
	logic [pfma_pkg::ADDR_W-1:0]   cur_out;

	// Address limit and stack index
	always_comb begin
		lim      = (LW'(mem_size_q) > LIM_MAX) ? LIM_MAX : LW'(mem_size_q);
		in_range = LW'(addr_q) < lim;
		pop_idx  = count_q - CW'(1);
	end

	// Memory controls
	always_comb begin
		byte_we = ctl.exec && (cmd_q == pfma_pkg::CMD_WRITE) && in_range;
		byte_re = ctl.exec && (cmd_q == pfma_pkg::CMD_READ) && in_range;
		stk_re  = ctl.exec && (cmd_q == pfma_pkg::CMD_ALLOC) && (count_q != '0);
		stk_we  = ctl.exec && (cmd_q == pfma_pkg::CMD_FREE) && (count_q != FRM_MAX);
	end

	pfma_ram #(
		.WIDTH (pfma_pkg::BYTE_W),
		.DEPTH (MEM_BYTES)
	) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (AW'(addr_q)),
		.wdata (wbyte_q),
		.re    (byte_re),
		.raddr (AW'(addr_q)),
		.rdata (byte_rd)
	);

	pfma_ram #(
		.WIDTH (pfma_pkg::FRAME_W),
		.DEPTH (MAX_FRAMES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (count_q[SW-1:0]),
		.wdata (fin_q),
		.re    (stk_re),
		.raddr (pop_idx[SW-1:0]),
		.rdata (stk_rd)
	);

	// Status to the controller
	always_comb begin
		stat.is_format = (cmd_q == pfma_pkg::CMD_FORMAT);
		stat.fmt_done  = (fmt_rem_q < PAGE_LW) || (fmt_cnt_q == FRM_MAX);
		stat.out_free  = !out_valid_q || out_ready;
	end

	// Input payload
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q   <= in_data[2:0];
			addr_q  <= in_data[16:3];
			wbyte_q <= in_data[24:17];
			fin_q   <= in_data[30:25];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= pfma_pkg::MSIZE_W'(16384);
			random_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfma_pkg::REG_MEM_SIZE: mem_size_q <= cfg_data;
				pfma_pkg::REG_RANDOM:   random_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Command execution, stack bookkeeping and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			count_q  <= FRM_MAX;
			wm_q     <= FRM_MAX;
			fbase_q  <= FRM_MAX;
		end else if (ctl.exec) begin
			case (cmd_q) inside
				pfma_pkg::CMD_READ, pfma_pkg::CMD_WRITE: begin
					if (in_range && !random_q) begin
						cursor_q <= addr_q;
					end
				end
				pfma_pkg::CMD_ALLOC: begin
					if (count_q != '0) begin
						count_q <= pop_idx;
						if (pop_idx < wm_q) begin
							wm_q <= pop_idx;
						end
					end
				end
				pfma_pkg::CMD_FREE: begin
					if (count_q != FRM_MAX) begin
						count_q <= count_q + CW'(1);
					end
				end
				default: ;
			endcase
		end else if (ctl.fmt_finish && fmt_cnt_q != '0) begin
			count_q <= fmt_cnt_q;
			wm_q    <= fmt_cnt_q;
			fbase_q <= fmt_cnt_q;
		end
	end

	// Status and flags of an executed command
	always_comb begin
		ex_status = pfma_pkg::ST_OK;
		ex_rd_ok  = 1'b0;
		ex_al_ok  = 1'b0;
		case (cmd_q) inside
			pfma_pkg::CMD_READ, pfma_pkg::CMD_WRITE: begin
				if (!in_range) begin
					ex_status = pfma_pkg::ST_RANGE;
				end else begin
					ex_rd_ok = (cmd_q == pfma_pkg::CMD_READ);
				end
			end
			pfma_pkg::CMD_ALLOC: begin
				if (count_q == '0) begin
					ex_status = pfma_pkg::ST_NOFRAME;
				end else begin
					ex_al_ok = 1'b1;
				end
			end
			pfma_pkg::CMD_FREE: begin
				if (count_q == FRM_MAX) begin
					ex_status = pfma_pkg::ST_FULL;
				end
			end
			default: ;
		endcase
	end

	// Result fields and format walk
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			rd_ok_q      <= ex_rd_ok;
			al_ok_q      <= ex_al_ok;
			res_status_q <= ex_status;
			pris_q       <= pop_idx < wm_q;
			pval_q       <= pfma_pkg::FRAME_W'(fbase_q - count_q);
		end
		if (ctl.fmt_init) begin
			fmt_rem_q    <= lim;
			fmt_cnt_q    <= '0;
			rd_ok_q      <= 1'b0;
			al_ok_q      <= 1'b0;
			res_status_q <= pfma_pkg::ST_OK;
		end
		if (ctl.fmt_step) begin
			fmt_rem_q <= fmt_rem_q - PAGE_LW;
			fmt_cnt_q <= fmt_cnt_q + CW'(1);
		end
		if (ctl.fmt_finish && fmt_cnt_q == '0) begin
			res_status_q <= pfma_pkg::ST_ZERO;
		end
	end

	// Output fields
	always_comb begin
		rb_out  = rd_ok_q ? byte_rd : '0;
		fr_out  = al_ok_q ? (pris_q ? pval_q : stk_rd) : '0;
		cur_out = random_q ? '0 : cursor_q;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_data_q <= {1'b0, cur_out, fr_out, rb_out, res_status_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== src/physical_frame_memory_allocator.sv =====
// Byte-addressed physical memory with a last-in first-out free-frame list.
// Input stream (s_*): one command item per handshake: read byte, write byte,
// format, allocate frame or free frame. Output stream (m_*): exactly one
// result item per command, in order: status, byte read, frame handed out
// and the cursor (sequential mode only).
// Configuration: cfg_we writes register cfg_index (0 mem_size, 1
// random_access) at the clock edge; write only while no command is in flight.
// Timing: a command is taken in the idle state, executed in the next cycle
// against the byte memory or the stack memory, and its result is loaded
// into the output register from the done state once that register is free;
// only then is the next command taken. Format counts the frames that fit by
// stepping through the pages, one page per cycle. The memory reads are
// registered, and the controller handles one command at a time.
// Reset: the stack holds all frames with frame 0 on top, cursor is zero,
// mem_size 16384, random access. No clearing pass; the byte memory is
// undefined until written.
// Stall: the output register holds the result while m_tready is low; the
// next command is still taken, but its result waits until the register frees.
module physical_frame_memory_allocator #(
	parameter int MEM_BYTES  = 16384,
	parameter int PAGE_BYTES = 256,
	parameter int MAX_FRAMES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// cmd[2:0], addr[16:3], write_byte[24:17], frame_in[30:25], zero [31]
	input  logic [pfma_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// status[2:0], read_byte[10:3], frame_out[16:11], cursor_pos[30:17], zero [31]
	output logic [pfma_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [pfma_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfma_pkg::CFG_DATA_W-1:0]     cfg_data
);

	pfma_pkg::ctl_cmd_t   ctl;
	pfma_pkg::dp_status_t stat;

	pfma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	pfma_dp #(
		.MEM_BYTES  (MEM_BYTES),
		.PAGE_BYTES (PAGE_BYTES),
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// ===== src/pfma_checker.sv =====
module pfma_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [pfma_pkg::OUT_DATA_W-1:0]   m_tdata
);

	// One command at a time: no item taken right after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while previous command in flight");

	// Status code is always a defined one
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= pfma_pkg::ST_ZERO))
		else $error("undefined status code");

	// Failed commands return no byte and no frame
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] != pfma_pkg::ST_OK) |-> (m_tdata[16:3] == '0))
		else $error("data returned on failed command");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind physical_frame_memory_allocator pfma_checker u_pfma_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
